// ===== hw/rtl/rcl_pkg.sv =====
`default_nettype none
package rcl_pkg;
    localparam int MAX_CAP_POINTS_DEF = 30;
    localparam int COORD_BITS_DEF     = 16;
    localparam int CORDIC_STEPS       = 24;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
    localparam logic [4:0]  CAP_RESET    = 5'd6;
    localparam logic [0:0]  REG_CAP_POINTS = 1'b0;

    // Work item handed from the front end to the vertex engine.
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [15:0]        w;
        logic [31:0]        phi;
        logic [4:0]         n;
    } seg_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/rcl_front.sv =====
`default_nettype none
// Accepts segments and finds their direction angle with a pipelined
// vectoring CORDIC, one step per stage.
module rcl_front
    import rcl_pkg::*;
#(
    parameter int MAX_CAP_POINTS = MAX_CAP_POINTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [79:0] in_data,
    input  wire logic [4:0]  cap_points,
    output logic             out_valid,
    input  wire logic        out_ready,
    output seg_t             out_seg
);
    localparam int S = CORDIC_STEPS;
    // x and y span (2^17)*2^14 plus CORDIC growth.
    localparam int VW = 34;

    logic               v_reg   [0:S];
    logic signed [VW-1:0] x_reg [0:S];
    logic signed [VW-1:0] y_reg [0:S];
    logic [31:0]        a_reg   [0:S];
    logic               z_reg   [0:S];
    seg_t               seg_reg [0:S];
    logic               adv;

    assign adv       = !v_reg[S] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[S];

    always_comb begin
        out_seg     = seg_reg[S];
        out_seg.phi = z_reg[S] ? 32'd0 : a_reg[S];
    end

    logic signed [16:0] dx, dy;
    logic [4:0]         n_sat;
    assign dx = 17'(signed'(in_data[47:32])) - 17'(signed'(in_data[15:0]));
    assign dy = 17'(signed'(in_data[63:48])) - 17'(signed'(in_data[31:16]));
    assign n_sat = (32'(cap_points) > MAX_CAP_POINTS) ? 5'(MAX_CAP_POINTS) : cap_points;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= S; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= S; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            seg_reg[0].sx  <= signed'(in_data[15:0]);
            seg_reg[0].sy  <= signed'(in_data[31:16]);
            seg_reg[0].ex  <= signed'(in_data[47:32]);
            seg_reg[0].ey  <= signed'(in_data[63:48]);
            seg_reg[0].w   <= in_data[79:64];
            seg_reg[0].phi <= 32'd0;
            seg_reg[0].n   <= n_sat;
            z_reg[0]       <= (dx == 17'sd0) && (dy == 17'sd0);
            if (dx < 0) begin
                x_reg[0] <= -(VW'(dx) <<< 14);
                y_reg[0] <= -(VW'(dy) <<< 14);
                a_reg[0] <= HALF_TURN;
            end else begin
                x_reg[0] <= VW'(dx) <<< 14;
                y_reg[0] <= VW'(dy) <<< 14;
                a_reg[0] <= 32'd0;
            end
            for (int i = 0; i < S; i++) begin
                seg_reg[i+1] <= seg_reg[i];
                z_reg[i+1]   <= z_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_turn(5'(i));
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_turn(5'(i));
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rcl_fifo.sv =====
`default_nettype none
// Short queue between the angle front end and the vertex engine.
module rcl_fifo
    import rcl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  seg_t      in_seg,
    output logic      out_valid,
    input  wire logic out_ready,
    output seg_t      out_seg
);
    seg_t       mem_reg [0:3];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = cnt_reg != 3'd4;
    assign out_valid = cnt_reg != 3'd0;
    assign out_seg   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= in_seg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 2'd1;
            if (rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr) - 3'(rd);
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4) else $error("queue count overflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 3'd1) else $error("count slip");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 3'd0) |-> !rd) else $error("read from empty queue");
endmodule
`default_nettype wire

// ===== hw/rtl/rcl_back.sv =====
`default_nettype none
// Vertex engine: a sequencer issues one vertex angle per cycle, unless the output
// stalls, into a pipelined rotation CORDIC; the cap step divide is one quotient bit
// a cycle at segment start, and each cap point's step is then advanced incrementally.
module rcl_back
    import rcl_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  seg_t              in_seg,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [31:0]       out_data,
    output logic [5:0]        out_index,
    output logic              out_last
);
    localparam int S  = CORDIC_STEPS;
    localparam int VW = 36;
    localparam int COORD_BITS = COORD_BITS_DEF;
    typedef enum logic [1:0] {IDLE, DIV, EMIT} st_t;

    function automatic logic [15:0] sat(input logic signed [COORD_BITS+1:0] v);
        logic signed [COORD_BITS+1:0] hi, lo;
        begin
            hi = (COORD_BITS+2)'((64'sd1 <<< (COORD_BITS - 1)) - 1);
            lo = -hi - 1;
            if (v > hi) return 16'(hi);
            if (v < lo) return 16'(lo);
            return 16'(v);
        end
    endfunction

    st_t         st_reg;
    seg_t        seg_reg;
    logic [5:0]  k_reg;      // vertex index being issued
    logic [5:0]  rem_reg;
    logic [31:0] q_reg;      // quotient 2^31/(n+1) floor
    logic [5:0]  r0_reg;     // remainder of 2^31/(n+1)
    logic [5:0]  bit_reg;
    logic [31:0] cap_step_reg;
    logic        adv;

    logic [5:0] np1, total_m1;
    assign np1      = 6'(seg_reg.n) + 6'd1;
    assign total_m1 = 6'(2 * seg_reg.n) + 6'd3;

    // Restoring divide of 2^31 by n+1, one bit a cycle.
    logic [6:0] trial;
    assign trial = {r0_reg, (bit_reg == 6'd31)};

    // Rounded step for cap point: floor((k*2^31 + (n+1)/2)/(n+1)), advanced
    // incrementally by adding q and r each point.
    logic [6:0] rsum;
    logic [5:0] half;
    assign half = np1 >> 1;
    assign rsum = 7'(rem_reg) + 7'(r0_reg);

    logic        issue;
    logic [31:0] theta;
    logic        use_end;
    logic [5:0]  nn;
    assign nn = 6'(seg_reg.n);
    always_comb begin
        logic [31:0] mn, pn;
        mn = seg_reg.phi - QUARTER_TURN;
        pn = seg_reg.phi + QUARTER_TURN;
        if (k_reg == 6'd0) begin
            theta = mn; use_end = 1'b0;
        end else if (k_reg == 6'd1) begin
            theta = mn; use_end = 1'b1;
        end else if (k_reg <= nn + 6'd1) begin
            theta = mn + cap_step_reg; use_end = 1'b1;
        end else if (k_reg == nn + 6'd2) begin
            theta = pn; use_end = 1'b1;
        end else if (k_reg == nn + 6'd3) begin
            theta = pn; use_end = 1'b0;
        end else begin
            theta = pn + cap_step_reg; use_end = 1'b0;
        end
    end

    // Pipeline of rotation stages.
    logic               pv_reg [0:S+2];
    logic signed [VW-1:0] px_reg [0:S];
    logic signed [VW-1:0] py_reg [0:S];
    logic signed [32:0] pz_reg [0:S];
    logic signed [15:0] bx_reg [0:S+2];
    logic signed [15:0] by_reg [0:S+2];
    logic [5:0]         ix_reg [0:S+2];
    logic               lt_reg [0:S+2];
    logic [47:0]        prod_reg;
    logic [31:0]        th_reg;
    logic signed [COORD_BITS+1:0] sx_reg, sy_reg;

    // Output register: while it holds a vertex that is not taken, stall the whole pipe.
    logic ov_reg;
    logic [31:0] od_reg;
    logic        ol_reg;
    logic [5:0]  oi_reg;
    assign adv       = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_index = oi_reg;
    assign out_last  = ol_reg;

    assign in_ready = (st_reg == IDLE);
    assign issue    = (st_reg == EMIT) && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= IDLE;
        end else begin
            unique case (st_reg)
                IDLE: if (in_valid) begin
                    seg_reg <= in_seg;
                    r0_reg  <= '0;
                    q_reg   <= '0;
                    bit_reg <= 6'd31;
                    st_reg  <= DIV;
                end
                DIV: begin
                    if (trial >= 7'(np1)) begin
                        r0_reg <= 6'(trial - 7'(np1));
                        q_reg  <= {q_reg[30:0], 1'b1};
                    end else begin
                        r0_reg <= trial[5:0];
                        q_reg  <= {q_reg[30:0], 1'b0};
                    end
                    if (bit_reg == 6'd0) begin
                        st_reg <= EMIT;
                        k_reg  <= '0;
                    end
                    bit_reg <= bit_reg - 6'd1;
                end
                EMIT: if (adv) begin
                    // Cap steps restart at each cap.
                    if (k_reg == 6'd1 || k_reg == nn + 6'd3) begin
                        cap_step_reg <= q_reg + 32'(({1'b0, half} + 7'(r0_reg)) >= 7'(np1));
                        rem_reg <= 6'((7'(half) + 7'(r0_reg) >= 7'(np1)) ?
                                   7'(half) + 7'(r0_reg) - 7'(np1) :
                                   7'(half) + 7'(r0_reg));
                    end else begin
                        cap_step_reg <= cap_step_reg + q_reg + 32'(rsum >= 7'(np1));
                        rem_reg <= 6'((rsum >= 7'(np1)) ? rsum - 7'(np1) : rsum);
                    end
                    if (k_reg == total_m1) st_reg <= IDLE;
                    k_reg <= k_reg + 6'd1;
                end
                default: st_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= S + 2; i++) pv_reg[i] <= 1'b0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            pv_reg[0] <= issue;
            for (int i = 1; i <= S + 2; i++) pv_reg[i] <= pv_reg[i-1];
            ov_reg <= pv_reg[S+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [31:0] th;
            th = theta;
            prod_reg <= 48'(seg_reg.w) * 48'(INV_GAIN_Q30);
            th_reg   <= th;
            bx_reg[0] <= use_end ? seg_reg.ex : seg_reg.sx;
            by_reg[0] <= use_end ? seg_reg.ey : seg_reg.sy;
            ix_reg[0] <= k_reg;
            lt_reg[0] <= (k_reg == total_m1);
            for (int i = 1; i <= S + 2; i++) begin
                bx_reg[i] <= bx_reg[i-1];
                by_reg[i] <= by_reg[i-1];
                ix_reg[i] <= ix_reg[i-1];
                lt_reg[i] <= lt_reg[i-1];
            end
            if ((th_reg - QUARTER_TURN) < HALF_TURN) begin
                px_reg[0] <= -VW'(prod_reg >> 15);
                pz_reg[0] <= 33'(signed'(th_reg - HALF_TURN));
            end else begin
                px_reg[0] <= VW'(prod_reg >> 15);
                pz_reg[0] <= 33'(signed'(th_reg));
            end
            py_reg[0] <= '0;
            for (int i = 0; i < S - 1; i++) begin
                if (pz_reg[i] >= 0) begin
                    px_reg[i+1] <= px_reg[i] - (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] + (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] - 33'(atan_turn(5'(i)));
                end else begin
                    px_reg[i+1] <= px_reg[i] + (py_reg[i] >>> i);
                    py_reg[i+1] <= py_reg[i] - (px_reg[i] >>> i);
                    pz_reg[i+1] <= pz_reg[i] + 33'(atan_turn(5'(i)));
                end
            end
            if (pz_reg[S-1] >= 0) begin
                px_reg[S] <= px_reg[S-1] - (py_reg[S-1] >>> (S - 1));
                py_reg[S] <= py_reg[S-1] + (px_reg[S-1] >>> (S - 1));
            end else begin
                px_reg[S] <= px_reg[S-1] + (py_reg[S-1] >>> (S - 1));
                py_reg[S] <= py_reg[S-1] - (px_reg[S-1] >>> (S - 1));
            end
            pz_reg[S] <= '0;
            sx_reg <= (COORD_BITS+2)'(bx_reg[S+1]) +
                      (COORD_BITS+2)'((px_reg[S] + VW'(32768)) >>> 16);
            sy_reg <= (COORD_BITS+2)'(by_reg[S+1]) +
                      (COORD_BITS+2)'((py_reg[S] + VW'(32768)) >>> 16);
            od_reg <= {sat(sy_reg), sat(sx_reg)};
            ol_reg <= lt_reg[S+2];
            oi_reg <= ix_reg[S+2];
        end
    end

    a_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> st_reg == EMIT) else $error("issue outside emit");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && k_reg == total_m1) |=> st_reg == IDLE) else $error("no return");
    a_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == EMIT) |-> k_reg <= total_m1) else $error("index overrun");
endmodule
`default_nettype wire

// ===== hw/rtl/round_cap_line_outline.sv =====
`default_nettype none
// Round-cap thick line outline. Each segment yields 2*N+4 vertices, one per
// cycle at the output while m_tready is held, N being cap_points (limited to
// MAX_CAP_POINTS): the vertex sequencer also spends setup time on the cap step
// divide of each segment, while the direction CORDIC of following segments
// runs ahead through a four-entry queue. cap_points lies at address 0, reset 6.
module round_cap_line_outline
    import rcl_pkg::*;
#(
    parameter int MAX_CAP_POINTS = MAX_CAP_POINTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // start_x, start_y, end_x, end_y, line_width
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // vertex_x, vertex_y, vertex_index, zero pad
    output logic [39:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [4:0] cap_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAP_POINTS) ? 32'(cap_reg) : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_CAP_POINTS)
            cap_reg <= pwdata[4:0];
    end

    seg_t f_seg, q_seg;
    logic f_v, f_r, q_v, q_r;
    logic [31:0] b_data;
    logic [5:0]  b_index;

    rcl_front #(.MAX_CAP_POINTS(MAX_CAP_POINTS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .cap_points(cap_reg), .out_valid(f_v), .out_ready(f_r), .out_seg(f_seg));
    rcl_fifo u_fifo (.aclk, .aresetn, .in_valid(f_v), .in_ready(f_r), .in_seg(f_seg),
        .out_valid(q_v), .out_ready(q_r), .out_seg(q_seg));
    rcl_back u_back (
        .aclk, .aresetn, .in_valid(q_v), .in_ready(q_r), .in_seg(q_seg),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(b_data),
        .out_index(b_index), .out_last(m_tlast));
    assign m_tdata = {2'b00, b_index, b_data};
endmodule
`default_nettype wire
